### design/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the byte run-length encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

	localparam int BYTE_W             = 8;
	localparam int LEN_W              = 8;
	localparam int WORD_W             = 64;
	localparam int CNT_W              = 4;
	localparam int LANES              = WORD_W / BYTE_W;
	localparam int RUN_FLAG           = 128;
	localparam int MAX_RUN_DEF        = 128;
	localparam int BYTES_PER_WORD_DEF = 8;
	localparam int CMDQ_DEPTH         = 4;
	localparam int OUTQ_DEPTH         = 4;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              stream_end;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_word;
		logic [CNT_W-1:0]  byte_count;
		logic              group_last;
		logic              stream_last;
	} out_item_t;

	// one input's worth of segments: a run and/or a literal, in either order
	typedef struct packed {
		logic              first_lit;
		logic              run_en;
		logic [BYTE_W-1:0] run_byte;
		logic [LEN_W-1:0]  run_len;
		logic              lit_en;
		logic [LEN_W-1:0]  lit_stored;
		logic              lit_tail_en;
		logic [BYTE_W-1:0] lit_tail;
		logic              lit_bank;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} lit_done_t;

endpackage

### design/brle_ram.sv
// ----------------------------------------------------------------------------
// brle_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module brle_ram #(
	parameter int WIDTH = brle_pkg::BYTE_W,
	parameter int DEPTH = 2 * brle_pkg::MAX_RUN_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/brle_fifo.sv
// ----------------------------------------------------------------------------
// brle_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module brle_fifo #(
	parameter type T     = brle_pkg::cmd_t,
	parameter int  DEPTH = brle_pkg::CMDQ_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wr_data,
	output logic full,
	input  logic pop,
	output T     rd_data,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

### design/brle_front.sv
// ----------------------------------------------------------------------------
// brle_front
// Takes raw bytes, tracks run/literal state, fills the literal store and
// issues one segment command per input that completes output.
// ----------------------------------------------------------------------------
module brle_front #(
	parameter int MAX_RUN = brle_pkg::MAX_RUN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  brle_pkg::in_item_t          item,
	output logic                        full,
	output logic                        cmd_push,
	output brle_pkg::cmd_t              cmd,
	input  logic                        cmd_full,
	input  brle_pkg::lit_done_t         lit_done,
	output logic                        wr_en,
	output logic [$clog2(MAX_RUN):0]    wr_addr,
	output logic [brle_pkg::BYTE_W-1:0] wr_data
);

	localparam int IDX_W = $clog2(MAX_RUN);
	localparam int LEN_W = brle_pkg::LEN_W;
	localparam bit RUN_CAP_TWO = (MAX_RUN <= 2);

	typedef enum logic [1:0] {
		M_IDLE,
		M_LIT,
		M_RUN
	} mode_t;

	mode_t                       mode_q, mode_d;
	logic [brle_pkg::BYTE_W-1:0] held_q, held_d;
	logic [LEN_W-1:0]            len_q, len_d;
	logic                        bank_q, bank_d;
	logic [1:0]                  busy_q, busy_set, busy_clr;
	logic [LEN_W-1:0]            len_inc;
	logic                        accept;
	logic                        same;
	logic                        last;

	assign full    = cmd_full || busy_q[bank_q];
	assign accept  = push && !full;
	assign same    = item.data_byte == held_q;
	assign last    = item.stream_end;
	assign len_inc = len_q + LEN_W'(1);
	assign wr_addr = {bank_q, len_q[IDX_W-1:0]};
	assign wr_data = held_q;

	always_comb begin
		mode_d       = mode_q;
		held_d       = held_q;
		len_d        = len_q;
		bank_d       = bank_q;
		cmd          = '0;
		cmd.last     = last;
		cmd.lit_bank = bank_q;
		cmd.run_byte = held_q;
		cmd_push     = 1'b0;
		wr_en        = 1'b0;
		if (accept) begin
			unique case (mode_q)
				M_IDLE: begin
					if (last) begin
						cmd.lit_en      = 1'b1;
						cmd.lit_tail_en = 1'b1;
						cmd.lit_tail    = item.data_byte;
						cmd_push        = 1'b1;
					end else begin
						held_d = item.data_byte;
						mode_d = M_LIT;
						len_d  = '0;
					end
				end
				M_RUN: begin
					if (same) begin
						if (len_inc >= LEN_W'(MAX_RUN) || last) begin
							cmd.run_en  = 1'b1;
							cmd.run_len = len_inc;
							cmd_push    = 1'b1;
							mode_d      = M_IDLE;
							len_d       = '0;
						end else begin
							len_d = len_inc;
						end
					end else begin
						cmd.run_en  = 1'b1;
						cmd.run_len = len_q;
						cmd_push    = 1'b1;
						if (last) begin
							cmd.lit_en      = 1'b1;
							cmd.lit_tail_en = 1'b1;
							cmd.lit_tail    = item.data_byte;
							mode_d          = M_IDLE;
							len_d           = '0;
						end else begin
							held_d = item.data_byte;
							mode_d = M_LIT;
							len_d  = '0;
						end
					end
				end
				M_LIT: begin
					if (same) begin
						cmd.first_lit = 1'b1;
						if (len_q != '0) begin
							cmd.lit_en     = 1'b1;
							cmd.lit_stored = len_q;
							bank_d         = !bank_q;
						end
						if (last || RUN_CAP_TWO) begin
							cmd.run_en  = 1'b1;
							cmd.run_len = LEN_W'(2);
							mode_d      = M_IDLE;
							len_d       = '0;
						end else begin
							mode_d = M_RUN;
							len_d  = LEN_W'(2);
						end
						cmd_push = cmd.lit_en || cmd.run_en;
					end else begin
						wr_en = 1'b1;
						if (last) begin
							cmd.lit_en      = 1'b1;
							cmd.lit_stored  = len_inc;
							cmd.lit_tail_en = 1'b1;
							cmd.lit_tail    = item.data_byte;
							cmd_push        = 1'b1;
							bank_d          = !bank_q;
							mode_d          = M_IDLE;
							len_d           = '0;
						end else if (len_inc >= LEN_W'(MAX_RUN - 1)) begin
							cmd.lit_en     = 1'b1;
							cmd.lit_stored = len_inc;
							cmd_push       = 1'b1;
							bank_d         = !bank_q;
							held_d         = item.data_byte;
							len_d          = '0;
						end else begin
							held_d = item.data_byte;
							len_d  = len_inc;
						end
					end
				end
				default: begin
					mode_d = M_IDLE;
					len_d  = '0;
				end
			endcase
		end
	end

	// a bank stays busy until the back end has read its last stored byte
	always_comb begin
		busy_set = '0;
		busy_clr = '0;
		if (cmd_push && cmd.lit_stored != '0) begin
			busy_set[bank_q] = 1'b1;
		end
		if (lit_done.valid) begin
			busy_clr[lit_done.bank] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			held_q <= '0;
			len_q  <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			mode_q <= mode_d;
			held_q <= held_d;
			len_q  <= len_d;
			bank_q <= bank_d;
			busy_q <= (busy_q | busy_set) & ~busy_clr;
		end
	end

endmodule

### design/brle_back.sv
// ----------------------------------------------------------------------------
// brle_back
// Walks each segment command byte by byte, reading literal bytes from the
// store, and packs the bytes into result words.
// ----------------------------------------------------------------------------
module brle_back #(
	parameter int MAX_RUN        = brle_pkg::MAX_RUN_DEF,
	parameter int BYTES_PER_WORD = brle_pkg::BYTES_PER_WORD_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_empty,
	output logic                        cmd_pop,
	input  brle_pkg::cmd_t              cmd,
	output logic                        rd_en,
	output logic [$clog2(MAX_RUN):0]    rd_addr,
	input  logic [brle_pkg::BYTE_W-1:0] rd_data,
	output brle_pkg::lit_done_t         lit_done,
	input  logic                        out_full,
	output logic                        out_push,
	output brle_pkg::out_item_t         out_item
);

	localparam int IDX_W  = $clog2(MAX_RUN);
	localparam int LEN_W  = brle_pkg::LEN_W;
	localparam int BYTE_W = brle_pkg::BYTE_W;
	localparam int WORD_W = brle_pkg::WORD_W;
	localparam int CNT_W  = brle_pkg::CNT_W;
	localparam int LANES  = brle_pkg::LANES;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LIT_HDR,
		S_LIT_BODY,
		S_LIT_TAIL,
		S_RUN_HDR,
		S_RUN_BYTE
	} state_t;

	state_t             state_q, state_nx, seg_next, tail_next, start_st;
	brle_pkg::cmd_t     cur_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   idx_rd;
	logic [WORD_W-1:0]  acc_q;
	logic [WORD_W-1:0]  word_nx;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_nx;
	logic [BYTE_W-1:0]  byte_val;
	logic               body_last;
	logic               step;
	logic               last_byte;
	logic               flush;

	assign body_last = (LEN_W'(idx_q) + LEN_W'(1)) == cur_q.lit_stored;
	assign step      = (state_q != S_IDLE) && !out_full;
	assign last_byte = state_nx == S_IDLE;
	assign cnt_nx    = cnt_q + CNT_W'(1);
	assign flush     = last_byte || cnt_nx == CNT_W'(BYTES_PER_WORD);
	assign cmd_pop   = (state_q == S_IDLE) && !cmd_empty;
	assign start_st  = (cmd.lit_en && (cmd.first_lit || !cmd.run_en)) ? S_LIT_HDR : S_RUN_HDR;

	always_comb begin
		unique case (state_q)
			S_LIT_HDR, S_LIT_BODY, S_LIT_TAIL: begin
				seg_next = (cur_q.first_lit && cur_q.run_en) ? S_RUN_HDR : S_IDLE;
			end
			default: begin
				seg_next = (!cur_q.first_lit && cur_q.lit_en) ? S_LIT_HDR : S_IDLE;
			end
		endcase
		tail_next = cur_q.lit_tail_en ? S_LIT_TAIL : seg_next;
	end

	always_comb begin
		byte_val = '0;
		state_nx = S_IDLE;
		unique case (state_q)
			S_LIT_HDR: begin
				byte_val = BYTE_W'(cur_q.lit_stored + LEN_W'(cur_q.lit_tail_en) - LEN_W'(1));
				state_nx = (cur_q.lit_stored != '0) ? S_LIT_BODY : tail_next;
			end
			S_LIT_BODY: begin
				byte_val = rd_data;
				state_nx = body_last ? tail_next : S_LIT_BODY;
			end
			S_LIT_TAIL: begin
				byte_val = cur_q.lit_tail;
				state_nx = seg_next;
			end
			S_RUN_HDR: begin
				byte_val = BYTE_W'(LEN_W'(brle_pkg::RUN_FLAG) + cur_q.run_len - LEN_W'(1));
				state_nx = S_RUN_BYTE;
			end
			S_RUN_BYTE: begin
				byte_val = cur_q.run_byte;
				state_nx = seg_next;
			end
			default: begin
				byte_val = '0;
				state_nx = S_IDLE;
			end
		endcase
	end

	// store read runs one byte ahead; rd_data holds while stalled
	assign idx_rd  = (state_q == S_LIT_HDR) ? '0 : idx_q + IDX_W'(1);
	assign rd_addr = {cur_q.lit_bank, idx_rd};
	assign rd_en   = step && ((state_q == S_LIT_HDR) || (state_q == S_LIT_BODY && !body_last));

	assign lit_done.valid = step && state_q == S_LIT_BODY && body_last;
	assign lit_done.bank  = cur_q.lit_bank;

	always_comb begin
		word_nx = acc_q;
		for (int i = 0; i < LANES; i++) begin
			if (cnt_q == CNT_W'(i)) begin
				word_nx[i*BYTE_W +: BYTE_W] = byte_val;
			end
		end
	end

	assign out_push             = step && flush;
	assign out_item.out_word    = word_nx;
	assign out_item.byte_count  = cnt_nx;
	assign out_item.group_last  = last_byte;
	assign out_item.stream_last = last_byte && cur_q.last;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd_pop) begin
				state_q <= start_st;
				idx_q   <= '0;
			end else if (step) begin
				state_q <= state_nx;
				if (state_q == S_LIT_HDR) begin
					idx_q <= '0;
				end else if (state_q == S_LIT_BODY) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (step) begin
				if (flush) begin
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					acc_q <= word_nx;
					cnt_q <= cnt_nx;
				end
			end
		end
	end

endmodule

### design/byte_run_length_encoder.sv
// Throughput: one input byte per cycle while the command queue has room and the
// literal bank being filled is free; the back end emits one byte per cycle while the
// output queue has room, and it takes a new command only once it is back in idle
// after the last byte of the previous one.
// Reset clears all control state at once; the literal store needs no clearing.
// ----------------------------------------------------------------------------
// byte_run_length_encoder
// Run-length encoder with decoupled classify and emit stages, packing the
// compressed stream into words of up to eight bytes.
// ----------------------------------------------------------------------------
module byte_run_length_encoder #(
	parameter int MAX_RUN        = brle_pkg::MAX_RUN_DEF,
	parameter int BYTES_PER_WORD = brle_pkg::BYTES_PER_WORD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  brle_pkg::in_item_t  item,
	output logic                full,
	output logic                empty,
	input  logic                pop,
	output brle_pkg::out_item_t result
);

	localparam int RAM_AW    = $clog2(MAX_RUN) + 1;
	localparam int RAM_DEPTH = 1 << RAM_AW;

	logic                        cmd_push;
	logic                        cmd_full;
	logic                        cmd_pop;
	logic                        cmd_empty;
	brle_pkg::cmd_t              cmd_wr;
	brle_pkg::cmd_t              cmd_rd;
	brle_pkg::lit_done_t         lit_done;
	logic                        wr_en;
	logic [RAM_AW-1:0]           wr_addr;
	logic [brle_pkg::BYTE_W-1:0] wr_data;
	logic                        rd_en;
	logic [RAM_AW-1:0]           rd_addr;
	logic [brle_pkg::BYTE_W-1:0] rd_data;
	logic                        out_push;
	logic                        out_full;
	brle_pkg::out_item_t         out_item;

	brle_front #(
		.MAX_RUN (MAX_RUN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_wr),
		.cmd_full (cmd_full),
		.lit_done (lit_done),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	brle_ram #(
		.WIDTH (brle_pkg::BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	brle_fifo #(
		.T     (brle_pkg::cmd_t),
		.DEPTH (brle_pkg::CMDQ_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	brle_back #(
		.MAX_RUN        (MAX_RUN),
		.BYTES_PER_WORD (BYTES_PER_WORD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd_rd),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.lit_done  (lit_done),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	brle_fifo #(
		.T     (brle_pkg::out_item_t),
		.DEPTH (brle_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (out_push),
		.wr_data (out_item),
		.full    (out_full),
		.pop     (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule
